>>> rtl/modular_arithmetic_unit_macros.svh
// ----------------------------------------------------------------------------
// Modular arithmetic unit assertion macros
// Shared property wrappers for the modular arithmetic unit RTL.
// ----------------------------------------------------------------------------
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

// implication checked every cycle outside reset
`define MAU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the following cycle
`define MAU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Widths, command codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none
package mau_pkg;
    localparam int W = 32;
    localparam int CW = $clog2(W + 1);

    typedef logic [W-1:0] word_t;
    typedef logic [CW-1:0] cnt_t;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_INV = 2'd3
    } cmd_t;
endpackage
`default_nettype wire

>>> rtl/mau_div.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit divider
// Restoring radix-2 divider, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_arithmetic_unit_macros.svh"
module mau_div
    import mau_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  start,
    input  wire word_t dividend,
    input  wire word_t divisor,
    output logic       busy,
    output logic       done,
    output word_t      quot,
    output word_t      rem
);
    logic  busy_reg, busy_next;
    logic  done_reg, done_next;
    cnt_t  cnt_reg, cnt_next;
    word_t q_reg, q_next;
    word_t r_reg, r_next;
    word_t d_reg, d_next;
    logic [W:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next = CW'(W);
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
        end else if (busy_reg) begin
            if (!trial[W]) begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = {r_reg[W-2:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
    assign rem = r_reg;

    `MAU_ASSERT_IMP(a_div_excl, aclk, aresetn, done_reg, !busy_reg)
    `MAU_ASSERT_NEXT(a_div_start, aclk, aresetn, start && !busy_reg, busy_reg)
    `MAU_ASSERT_IMP(a_div_cnt, aclk, aresetn, busy_reg, cnt_reg != '0)
endmodule
`default_nettype wire

>>> rtl/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Add, subtract, multiply and inverse modulo a configured modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat on s_valid/s_ready carries s_command, s_operand_a, s_operand_b.
//   Result beat on m_valid/m_ready carries m_result and m_status.
//   Write the modulus with modulus_we/modulus_wdata while idle; reset sets 2.
//   One item at a time: s_ready is low from acceptance until the result beat
//   is taken. All work runs on one shared restoring divider and one shared
//   modular adder.
//   Add/subtract run two operand reductions; multiply adds a shift-and-add
//   loop on top; inverse adds Euclid steps, each a division, a reduction of
//   the quotient, a shift-and-add multiply and a subtraction.
//   A stalled receiver holds the result in the output register; m_valid stays
//   high and no new beat is accepted until it is taken.
//   Reset clears the sequencer and restores the modulus to 2.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_arithmetic_unit_macros.svh"
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        modulus_we,
    input  wire word_t       modulus_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire word_t       s_operand_a,
    input  wire word_t       s_operand_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output word_t            m_result,
    output logic             m_status
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_REDA  = 10'b0000000010,
        S_REDB  = 10'b0000000100,
        S_ARITH = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_EDIV  = 10'b0000100000,
        S_QRED  = 10'b0001000000,
        S_TMUL  = 10'b0010000000,
        S_EUPD  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    word_t  mod_reg;
    cmd_t   cmd_reg, cmd_next;
    word_t  a_reg, a_next, b_reg, b_next;
    word_t  x_reg, x_next, y_reg, y_next;
    word_t  t0_reg, t0_next, t1_reg, t1_next;
    word_t  mx_reg, mx_next, my_reg, my_next, acc_reg, acc_next;
    word_t  r_reg, r_next;
    logic   sub_reg, sub_next;
    word_t  res_reg, res_next;
    logic   st_reg, st_next;
    logic   dstart, dbusy, ddone;
    word_t  dnd, dsr, dq, drem;

    // shared modular adder/subtractor (operands below modulus)
    word_t  u_x, u_y, u_out;
    logic   u_sub;
    logic [W:0] u_room, u_sum;

    always_comb begin
        u_room = {1'b0, mod_reg} - {1'b0, u_y};
        u_sum = {1'b0, u_x} + {1'b0, u_y};
        if (u_sub) begin
            u_out = (u_x >= u_y) ? (u_x - u_y) : (u_x + u_room[W-1:0]);
        end else begin
            u_out = ({1'b0, u_x} >= u_room) ? (u_x - u_room[W-1:0]) : u_sum[W-1:0];
        end
    end

    mau_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .dividend(dnd), .divisor(dsr), .busy(dbusy), .done(ddone),
        .quot(dq), .rem(drem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= W'(2);
        end else if (modulus_we) begin
            mod_reg <= modulus_wdata;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        a_next = a_reg; b_next = b_reg;
        x_next = x_reg; y_next = y_reg;
        t0_next = t0_reg; t1_next = t1_reg;
        mx_next = mx_reg; my_next = my_reg; acc_next = acc_reg;
        r_next = r_reg; sub_next = sub_reg;
        res_next = res_reg; st_next = st_reg;
        dstart = 1'b0; dnd = a_reg; dsr = mod_reg;
        u_x = a_reg; u_y = b_reg; u_sub = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = cmd_t'(s_command);
                    a_next = s_operand_a;
                    b_next = s_operand_b;
                    if (mod_reg < W'(2)) begin
                        res_next = '0;
                        st_next = (cmd_t'(s_command) == CMD_INV);
                        state_next = S_OUT;
                    end else begin
                        state_next = S_REDA;
                        sub_next = 1'b0;
                    end
                end
            end
            S_REDA: begin
                dnd = a_reg;
                dstart = !sub_next && !sub_reg;
                sub_next = 1'b1;
                if (ddone) begin
                    a_next = drem;
                    sub_next = 1'b0;
                    state_next = S_REDB;
                end
            end
            S_REDB: begin
                dnd = b_reg;
                dstart = !sub_reg;
                sub_next = 1'b1;
                if (ddone) begin
                    b_next = drem;
                    sub_next = 1'b0;
                    st_next = 1'b0;
                    unique case (cmd_reg)
                        CMD_ADD, CMD_SUB: state_next = S_ARITH;
                        CMD_MUL: begin
                            mx_next = a_reg; my_next = drem; acc_next = '0;
                            state_next = S_MUL;
                        end
                        CMD_INV: begin
                            x_next = mod_reg; y_next = a_reg;
                            t0_next = '0; t1_next = W'(1);
                            state_next = S_EUPD;
                        end
                        default: state_next = S_ARITH;
                    endcase
                end
            end
            S_ARITH: begin
                u_sub = (cmd_reg == CMD_SUB);
                res_next = u_out;
                state_next = S_OUT;
            end
            S_MUL: begin
                // alternate: sub_reg=0 accumulate, sub_reg=1 double and shift
                if (my_reg == '0) begin
                    if (cmd_reg == CMD_MUL) begin
                        res_next = acc_reg;
                        state_next = S_OUT;
                    end else begin
                        t1_next = acc_reg;
                        state_next = S_EUPD;
                        sub_next = 1'b0;
                    end
                end else if (!sub_reg) begin
                    u_x = acc_reg; u_y = mx_reg;
                    if (my_reg[0]) acc_next = u_out;
                    sub_next = 1'b1;
                end else begin
                    u_x = mx_reg; u_y = mx_reg;
                    mx_next = u_out;
                    my_next = my_reg >> 1;
                    sub_next = 1'b0;
                end
            end
            S_EUPD: begin
                if (sub_reg) begin
                    // tn = t0 - acc ; shift values
                    u_x = t0_reg; u_y = t1_reg; u_sub = 1'b1;
                    t0_next = mx_reg;
                    t1_next = u_out;
                    sub_next = 1'b0;
                end else if (y_reg == '0) begin
                    if (x_reg == W'(1)) begin
                        res_next = t0_reg; st_next = 1'b0;
                    end else begin
                        res_next = '0; st_next = 1'b1;
                    end
                    state_next = S_OUT;
                end else begin
                    dnd = x_reg; dsr = y_reg;
                    dstart = 1'b1;
                    state_next = S_EDIV;
                end
            end
            S_EDIV: begin
                dnd = x_reg; dsr = y_reg;
                if (ddone) begin
                    x_next = y_reg;
                    y_next = drem;
                    r_next = dq;
                    state_next = S_QRED;
                end
            end
            S_QRED: begin
                dnd = r_reg; dsr = mod_reg;
                dstart = !dbusy && !ddone && !sub_reg;
                sub_next = 1'b1;
                if (ddone) begin
                    // multiply (q mod m) by t1; keep old t1 in mx slot later
                    mx_next = drem; my_next = t1_reg; acc_next = '0;
                    r_next = t1_reg;
                    sub_next = 1'b0;
                    state_next = S_TMUL;
                end
            end
            S_TMUL: begin
                if (my_reg == '0) begin
                    // t1 <- product, mx <- old t1, then subtract in S_EUPD
                    t1_next = acc_reg;
                    mx_next = r_reg;
                    sub_next = 1'b1;
                    state_next = S_EUPD;
                end else if (!sub_reg) begin
                    u_x = acc_reg; u_y = mx_reg;
                    if (my_reg[0]) acc_next = u_out;
                    sub_next = 1'b1;
                end else begin
                    u_x = mx_reg; u_y = mx_reg;
                    mx_next = u_out;
                    my_next = my_reg >> 1;
                    sub_next = 1'b0;
                end
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sub_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sub_reg <= sub_next;
        end
        cmd_reg <= cmd_next;
        a_reg <= a_next; b_reg <= b_next;
        x_reg <= x_next; y_reg <= y_next;
        t0_reg <= t0_next; t1_reg <= t1_next;
        mx_reg <= mx_next; my_reg <= my_next; acc_reg <= acc_next;
        r_reg <= r_next;
        res_reg <= res_next; st_reg <= st_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_result = res_reg;
    assign m_status = st_reg;

    `MAU_ASSERT_IMP(a_excl, aclk, aresetn, s_ready, !m_valid)
    `MAU_ASSERT_IMP(a_res_range, aclk, aresetn, m_valid && mod_reg >= W'(2), m_result < mod_reg)
    `MAU_ASSERT_IMP(a_st_zero, aclk, aresetn, m_valid && m_status, m_result == '0)
    `MAU_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result))
endmodule
`default_nettype wire
